@@ hw/rtl/ptb_pkg.sv @@
// shared types, widths and operand tables for the barycentric point-in-triangle test
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int DotW   = ProdW + 1;
  localparam int NDot   = 5;
  localparam int NMul   = 6;
  localparam int LoW    = 26;
  localparam int HiW    = DotW - LoW;
  localparam int HhW    = 2 * HiW;
  localparam int MidW   = HiW + LoW + 1;
  localparam int LlW    = 2 * LoW;
  localparam int BigW   = 2 * DotW;
  localparam int NumW   = BigW + 1;
  localparam int MagW   = NumW;
  localparam int FracW  = 16;
  localparam int RemW   = MagW + FracW;
  localparam int QW     = 32;
  localparam int WgtW   = 32;
  localparam int SumW   = WgtW + 2;
  localparam int TolW   = 17;
  localparam logic [TolW-1:0] TolReset = TolW'(66);
  localparam logic [SumW-1:0] OneQ16 = SumW'(65536);

  // dot product codes
  localparam int DotUU = 0;
  localparam int DotVV = 1;
  localparam int DotUV = 2;
  localparam int DotUW = 3;
  localparam int DotVW = 4;

  // edge vector codes
  localparam int VecU = 0;
  localparam int VecV = 1;
  localparam int VecW = 2;

  typedef logic [2:0][CoordW-1:0] vec3_t;

  typedef struct packed {
    vec3_t pt;
    vec3_t v0;
    vec3_t v1;
    vec3_t v2;
  } tri_req_t;

  typedef logic [NDot-1:0][DotW-1:0] dots_t;

  typedef struct packed {
    logic [MagW-1:0] den;
    logic [NumW-1:0] gnum;
    logic [NumW-1:0] bnum;
  } cross_t;

  typedef struct packed {
    logic            degenerate;
    logic [WgtW-1:0] beta;
    logic [WgtW-1:0] gamma;
  } bg_t;

  typedef struct packed {
    logic            inside_res;
    logic            degenerate;
    logic [WgtW-1:0] alpha;
    logic [WgtW-1:0] beta;
    logic [WgtW-1:0] gamma;
  } res_t;

  // left and right edge vector of each dot product
  function automatic int dot_a(input int m);
    int r;
    unique case (m)
      DotUU, DotUV, DotUW: r = VecU;
      default:             r = VecV;
    endcase
    return r;
  endfunction

  function automatic int dot_b(input int m);
    int r;
    unique case (m)
      DotUU:        r = VecU;
      DotVV, DotUV: r = VecV;
      default:      r = VecW;
    endcase
    return r;
  endfunction

  // operands of the six wide products: uu*vv, uv*uv, uu*vw, uv*uw, uw*vv, vw*uv
  function automatic int mul_a(input int p);
    int r;
    unique case (p)
      0, 2:    r = DotUU;
      1, 3:    r = DotUV;
      4:       r = DotUW;
      default: r = DotVW;
    endcase
    return r;
  endfunction

  function automatic int mul_b(input int p);
    int r;
    unique case (p)
      0, 4:    r = DotVV;
      1, 5:    r = DotUV;
      2:       r = DotVW;
      default: r = DotUW;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ptb_if.sv @@
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ptb_req_if;
  logic valid;
  logic ready;
  logic [ptb_pkg::CoordW-1:0] point_x;
  logic [ptb_pkg::CoordW-1:0] point_y;
  logic [ptb_pkg::CoordW-1:0] point_z;
  logic [ptb_pkg::CoordW-1:0] vertex0_x;
  logic [ptb_pkg::CoordW-1:0] vertex0_y;
  logic [ptb_pkg::CoordW-1:0] vertex0_z;
  logic [ptb_pkg::CoordW-1:0] vertex1_x;
  logic [ptb_pkg::CoordW-1:0] vertex1_y;
  logic [ptb_pkg::CoordW-1:0] vertex1_z;
  logic [ptb_pkg::CoordW-1:0] vertex2_x;
  logic [ptb_pkg::CoordW-1:0] vertex2_y;
  logic [ptb_pkg::CoordW-1:0] vertex2_z;
  modport source (output valid, point_x, point_y, point_z, vertex0_x, vertex0_y, vertex0_z,
                  vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, vertex0_x, vertex0_y, vertex0_z,
                vertex1_x, vertex1_y, vertex1_z, vertex2_x, vertex2_y, vertex2_z,
                output ready);
endinterface

interface ptb_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;
  logic [ptb_pkg::WgtW-1:0] weight_alpha;
  logic [ptb_pkg::WgtW-1:0] weight_beta;
  logic [ptb_pkg::WgtW-1:0] weight_gamma;
  modport source (output valid, inside_res, degenerate, weight_alpha, weight_beta,
                  weight_gamma, input ready);
  modport sink (input valid, inside_res, degenerate, weight_alpha, weight_beta,
                weight_gamma, output ready);
endinterface

interface ptb_cfg_if;
  logic valid;
  logic ready;
  logic [ptb_pkg::TolW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/point_triangle_barycentric_test_core.sv @@
// top level of the barycentric point-in-triangle test pipeline
`timescale 1ns / 1ps
`default_nettype none
// usage
//   req: one request per accepted valid/ready pair: query point and three vertices,
//        each coordinate signed q12.12
//   res: one result per request, in order: inside flag, degenerate flag and the
//        alpha, beta, gamma weights in signed q16.16, saturated
//   cfg: write-only tolerance register (unsigned q1.16), always ready
// timing
//   fully pipelined, a new request may enter on every cycle while the result is not held
//   stages in order: edge vectors and dot products, the wide products and their
//   differences, sign and range prep, the one-bit-per-stage divider, saturation,
//   and alpha with the band test
//   throughput is set by the divider depth only in latency, not in rate
// reset
//   clears every valid bit and loads the tolerance with its default of 66
// back-pressure
//   while the result register holds an item the sink has not taken, the whole
//   pipeline freezes and req.ready drops; nothing is dropped or repeated
module point_triangle_barycentric_test_core (
  input logic      clk,
  input logic      rst,
  ptb_req_if.sink  req,
  ptb_res_if.source res,
  ptb_cfg_if.sink  cfg
);
  import ptb_pkg::*;

  logic            en;
  logic [TolW-1:0] tolerance;
  tri_req_t        req_pk;
  logic            dot_vld, cross_vld, div_vld, out_vld;
  dots_t           dots;
  cross_t          terms;
  bg_t             bg;
  res_t            res_pk;

  // advance whenever the result register is empty or being taken
  assign en        = !out_vld || res.ready;
  assign req.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TolReset;
    end else if (cfg.valid) begin
      tolerance <= cfg.data;
    end
  end

  // element 0 is x, 1 is y, 2 is z
  assign req_pk.pt = {req.point_z, req.point_y, req.point_x};
  assign req_pk.v0 = {req.vertex0_z, req.vertex0_y, req.vertex0_x};
  assign req_pk.v1 = {req.vertex1_z, req.vertex1_y, req.vertex1_x};
  assign req_pk.v2 = {req.vertex2_z, req.vertex2_y, req.vertex2_x};

  ptb_dot u_dot (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (req.valid),
    .req     (req_pk),
    .out_vld (dot_vld),
    .dots    (dots)
  );

  ptb_cross u_cross (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (dot_vld),
    .dots    (dots),
    .out_vld (cross_vld),
    .terms   (terms)
  );

  ptb_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (cross_vld),
    .terms   (terms),
    .out_vld (div_vld),
    .bg      (bg)
  );

  ptb_out u_out (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (div_vld),
    .bg      (bg),
    .tol     (tolerance),
    .out_vld (out_vld),
    .res     (res_pk)
  );

  assign res.valid        = out_vld;
  assign res.inside_res   = res_pk.inside_res;
  assign res.degenerate   = res_pk.degenerate;
  assign res.weight_alpha = res_pk.alpha;
  assign res.weight_beta  = res_pk.beta;
  assign res.weight_gamma = res_pk.gamma;

endmodule
`default_nettype wire

@@ hw/rtl/ptb_dot.sv @@
// edge vectors and the five dot products, three stages
`timescale 1ns / 1ps
`default_nettype none
module ptb_dot (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  ptb_pkg::tri_req_t req,
  output logic              out_vld,
  output ptb_pkg::dots_t    dots
);
  import ptb_pkg::*;

  logic [2:0] vld;
  logic [2:0][DiffW-1:0] dv [3];
  logic [2:0][ProdW-1:0] pr [NDot];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv[VecU][k] <= {req.v1[k][CoordW-1], req.v1[k]} - {req.v0[k][CoordW-1], req.v0[k]};
        dv[VecV][k] <= {req.v2[k][CoordW-1], req.v2[k]} - {req.v0[k][CoordW-1], req.v0[k]};
        dv[VecW][k] <= {req.pt[k][CoordW-1], req.pt[k]} - {req.v0[k][CoordW-1], req.v0[k]};
      end
      for (int m = 0; m < NDot; m++) begin
        for (int k = 0; k < 3; k++) begin
          pr[m][k] <= $signed(dv[dot_a(m)][k]) * $signed(dv[dot_b(m)][k]);
        end
      end
      for (int m = 0; m < NDot; m++) begin
        dots[m] <= {pr[m][0][ProdW-1], pr[m][0]} + {pr[m][1][ProdW-1], pr[m][1]}
                 + {pr[m][2][ProdW-1], pr[m][2]};
      end
    end
  end

  assign out_vld = vld[2];

endmodule
`default_nettype wire

@@ hw/rtl/ptb_cross.sv @@
// wide products split into partials, then denominator and both numerators
`timescale 1ns / 1ps
`default_nettype none
module ptb_cross (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  ptb_pkg::dots_t  dots,
  output logic            out_vld,
  output ptb_pkg::cross_t terms
);
  import ptb_pkg::*;

  logic [2:0] vld;
  logic [HhW-1:0]  hh [NMul];
  logic [MidW-1:0] hl [NMul];
  logic [MidW-1:0] lh [NMul];
  logic [LlW-1:0]  ll [NMul];
  logic [MidW:0]   mid [NMul];
  logic [BigW-1:0] prod [NMul];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_comb begin
    for (int p = 0; p < NMul; p++) begin
      mid[p] = {hl[p][MidW-1], hl[p]} + {lh[p][MidW-1], lh[p]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // signed high halves and unsigned low halves multiplied pairwise, four partials per product
      for (int p = 0; p < NMul; p++) begin
        hh[p] <= $signed(dots[mul_a(p)][DotW-1:LoW]) * $signed(dots[mul_b(p)][DotW-1:LoW]);
        hl[p] <= $signed(dots[mul_a(p)][DotW-1:LoW]) * $signed({1'b0, dots[mul_b(p)][LoW-1:0]});
        lh[p] <= $signed({1'b0, dots[mul_a(p)][LoW-1:0]}) * $signed(dots[mul_b(p)][DotW-1:LoW]);
        ll[p] <= dots[mul_a(p)][LoW-1:0] * dots[mul_b(p)][LoW-1:0];
      end
      for (int p = 0; p < NMul; p++) begin
        prod[p] <= {hh[p], {(2*LoW){1'b0}}}
                 + {{(BigW-MidW-1-LoW){mid[p][MidW]}}, mid[p], {LoW{1'b0}}}
                 + {{(BigW-LlW){1'b0}}, ll[p]};
      end
      terms.den  <= {prod[0][BigW-1], prod[0]} - {prod[1][BigW-1], prod[1]};
      terms.gnum <= {prod[2][BigW-1], prod[2]} - {prod[3][BigW-1], prod[3]};
      terms.bnum <= {prod[4][BigW-1], prod[4]} - {prod[5][BigW-1], prod[5]};
    end
  end

  assign out_vld = vld[2];

endmodule
`default_nettype wire

@@ hw/rtl/ptb_div.sv @@
// pipelined restoring divider, one quotient bit per stage, gamma and beta lanes
`timescale 1ns / 1ps
`default_nettype none
module ptb_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  ptb_pkg::cross_t terms,
  output logic            out_vld,
  output ptb_pkg::bg_t    bg
);
  import ptb_pkg::*;

  logic [QW:0]     vld;
  logic [MagW-1:0] den_p [QW+1];
  logic [QW:0]     deg;
  logic [RemW-1:0] rem [2][QW+1];
  logic [QW-1:0]   qv  [2][QW+1];
  logic            neg [2][QW+1];
  logic            ovf [2][QW+1];
  logic [NumW-1:0] num [2];

  assign num[0] = terms.gnum;
  assign num[1] = terms.bnum;

  // truncated quotient to saturated signed q16.16
  function automatic logic [WgtW-1:0] sat_q(input logic [QW-1:0] q, input logic n,
                                            input logic o);
    logic [WgtW-1:0] r;
    if (n) begin
      if (o || q > {1'b1, {(QW-1){1'b0}}}) r = {1'b1, {(WgtW-1){1'b0}}};
      else r = WgtW'(0) - q;
    end else begin
      if (o || q[QW-1]) r = {1'b0, {(WgtW-1){1'b1}}};
      else r = q;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[QW-1:0], in_vld};
      out_vld <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_p[0] <= terms.den;
      deg[0]   <= (terms.den == '0);
      for (int i = 0; i < QW; i++) begin
        den_p[i+1] <= den_p[i];
        deg[i+1]   <= deg[i];
      end
      bg.degenerate <= deg[QW];
      bg.gamma      <= sat_q(qv[0][QW], neg[0][QW], ovf[0][QW]);
      bg.beta       <= sat_q(qv[1][QW], neg[1][QW], ovf[1][QW]);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [MagW-1:0] mag;

    assign mag = num[l][NumW-1] ? (~num[l] + NumW'(1)) : num[l];

    always_ff @(posedge clk) begin
      if (en) begin
        neg[l][0] <= num[l][NumW-1];
        // quotient of 2^32 or more saturates either way
        ovf[l][0] <= {{FracW{1'b0}}, mag} >= {terms.den, {FracW{1'b0}}};
        rem[l][0] <= {mag, {FracW{1'b0}}};
        qv[l][0]  <= '0;
      end
    end

    for (genvar i = 0; i < QW; i++) begin : g_step
      localparam int J = QW - 1 - i;
      logic            take;
      logic [RemW-1:0] sub;
      logic [QW-1:0]   qn;

      always_comb begin
        sub   = RemW'(den_p[i]) << J;
        take  = (rem[l][i] >> J) >= RemW'(den_p[i]);
        qn    = qv[l][i];
        qn[J] = take;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][i+1] <= take ? (rem[l][i] - sub) : rem[l][i];
          qv[l][i+1]  <= qn;
          neg[l][i+1] <= neg[l][i];
          ovf[l][i+1] <= ovf[l][i];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ptb_out.sv @@
// alpha from beta and gamma, tolerance band test, result register
`timescale 1ns / 1ps
`default_nettype none
module ptb_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  ptb_pkg::bg_t             bg,
  input  logic [ptb_pkg::TolW-1:0] tol,
  output logic                     out_vld,
  output ptb_pkg::res_t            res
);
  import ptb_pkg::*;

  logic signed [SumW-1:0] b_ext, g_ext, a_sum, a_sat, lo, hi;
  logic                   in_band;

  always_comb begin
    b_ext = {{(SumW-WgtW){bg.beta[WgtW-1]}}, bg.beta};
    g_ext = {{(SumW-WgtW){bg.gamma[WgtW-1]}}, bg.gamma};
    a_sum = OneQ16 - b_ext - g_ext;
    if (a_sum > $signed({{(SumW-WgtW+1){1'b0}}, {(WgtW-1){1'b1}}})) begin
      a_sat = {{(SumW-WgtW+1){1'b0}}, {(WgtW-1){1'b1}}};
    end else if (a_sum < $signed({{(SumW-WgtW+1){1'b1}}, {(WgtW-1){1'b0}}})) begin
      a_sat = {{(SumW-WgtW+1){1'b1}}, {(WgtW-1){1'b0}}};
    end else begin
      a_sat = a_sum;
    end
    lo = SumW'(0) - {{(SumW-TolW){1'b0}}, tol};
    hi = OneQ16 + {{(SumW-TolW){1'b0}}, tol};
    in_band = (a_sat >= lo) && (a_sat <= hi) && (b_ext >= lo) && (b_ext <= hi)
           && (g_ext >= lo) && (g_ext <= hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.degenerate <= bg.degenerate;
      res.inside_res <= in_band && !bg.degenerate;
      res.alpha      <= bg.degenerate ? '0 : a_sat[WgtW-1:0];
      res.beta       <= bg.degenerate ? '0 : bg.beta;
      res.gamma      <= bg.degenerate ? '0 : bg.gamma;
    end
  end

endmodule
`default_nettype wire
